>>> rtl/scanline_span_merger_macros.svh
// Assertion macros shared by the scanline span merger RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef SCANLINE_SPAN_MERGER_MACROS_SVH
`define SCANLINE_SPAN_MERGER_MACROS_SVH

// Property must hold at every edge outside reset.
`define SSM_CHECK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define SSM_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/ssm_pkg.sv
// Shared widths, status codes and helpers of the scanline span merger.
// No dependencies; used by ssm_seg_ram and scanline_span_merger.
package ssm_pkg;

  localparam int START_W = 12;
  localparam int LEN_W   = 13;
  localparam int CNT_W   = 13;
  localparam int LINE_W  = 10;
  localparam int OUTC_W  = 8;
  localparam int INC_W   = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

  typedef enum logic [2:0] {
    ST_APPEND   = 3'd0,
    ST_EXTEND   = 3'd1,
    ST_REWRITE  = 3'd2,
    ST_MERGE    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // Length of an inclusive column range, zero when last is below first.
  function automatic logic [LEN_W-1:0] span_len(input logic [START_W-1:0] first,
                                                input logic [START_W-1:0] last);
    logic [LEN_W-1:0] d;
    d = {1'b0, last} - {1'b0, first} + 13'd1;
    return (last >= first) ? d : '0;
  endfunction

endpackage

>>> rtl/ssm_seg_ram.sv
// Segment store: start, length and colour per pool entry.
// One write port, two registered read ports. Uses ssm_pkg widths.
module ssm_seg_ram #(
  parameter int DEPTH      = 12288,
  parameter int AW         = 14,
  parameter int COLOR_BITS = 8
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [ssm_pkg::START_W-1:0]  wstart,
  input  logic [ssm_pkg::LEN_W-1:0]    wlen,
  input  logic [COLOR_BITS-1:0]        wcolor,
  input  logic                         re,
  input  logic [AW-1:0]                raddr0,
  input  logic [AW-1:0]                raddr1,
  output logic [ssm_pkg::START_W-1:0]  rstart0,
  output logic [ssm_pkg::LEN_W-1:0]    rlen0,
  output logic [COLOR_BITS-1:0]        rcolor0,
  output logic [ssm_pkg::START_W-1:0]  rstart1,
  output logic [ssm_pkg::LEN_W-1:0]    rlen1,
  output logic [COLOR_BITS-1:0]        rcolor1
);

  localparam int DW = ssm_pkg::START_W + ssm_pkg::LEN_W + COLOR_BITS;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wstart, wlen, wcolor};
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      {rstart0, rlen0, rcolor0} <= mem[raddr0];
      {rstart1, rlen1, rcolor1} <= mem[raddr1];
    end
  end

endmodule

>>> rtl/scanline_span_merger.sv
// Scanline span merger top level: line table, pool tops, control sequencer.
// Depends on ssm_pkg, ssm_seg_ram and scanline_span_merger_macros.svh.
//
// Each accepted span is folded into the run-length segments of its scan line
// and one result item reports the line's tail segment afterward. An item goes
// through line table read, segment read of tail and entry below it, decide and
// write, and result before the next item is accepted. Decide and write is
// skipped when the pool selector is out of range, and the segment read as well
// for a line at or above NUM_LINES. A second write step follows decide and
// write when a tail cut appends a new segment or a span merges into the entry
// below, since the segment memory has a single write port. The result step
// holds while the result channel stalls and the previous result still waits.
// After reset the line table is cleared one entry per cycle over all NUM_LINES
// entries before the first item is taken; configuration writes are taken during that pass.
`include "scanline_span_merger_macros.svh"

module scanline_span_merger #(
  parameter int NUM_LINES  = 1024,
  parameter int POOL_DEPTH = 4096,
  parameter int NUM_POOLS  = 3,
  parameter int COLOR_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ssm_pkg::LINE_W-1:0]    in_line,
  input  logic [ssm_pkg::START_W-1:0]   in_span_start,
  input  logic [ssm_pkg::START_W-1:0]   in_span_end,
  input  logic [ssm_pkg::INC_W-1:0]     in_span_color,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [ssm_pkg::START_W-1:0]   out_tail_start,
  output logic [ssm_pkg::LEN_W-1:0]     out_tail_length,
  output logic [ssm_pkg::OUTC_W-1:0]    out_tail_color,
  output logic [ssm_pkg::CNT_W-1:0]     out_segments_on_line
);

  localparam int LAW  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int TAW  = $clog2(POOL_DEPTH);
  localparam int TOPW = $clog2(POOL_DEPTH + 1);
  localparam int PW   = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int SEGS = NUM_POOLS * POOL_DEPTH;
  localparam int SAW  = $clog2(SEGS);
  localparam int SW   = ssm_pkg::START_W;
  localparam int LW   = ssm_pkg::LEN_W;
  localparam int CW   = ssm_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LINE, S_SEG, S_WR2, S_OUT
  } state_t;

  state_t                 state_r;
  logic [LAW-1:0]         clr_r;
  logic [1:0]             pool_r;
  logic [TOPW-1:0]        pool_top_r [NUM_POOLS];

  logic [LAW-1:0]         line_r;
  logic [SW-1:0]          s_r, e_r;
  logic [COLOR_BITS-1:0]  c_r;

  // line table: count and tail index per line
  logic [CW-1:0]          lm_cnt  [NUM_LINES];
  logic [TAW-1:0]         lm_tail [NUM_LINES];
  logic [CW-1:0]          lq_cnt;
  logic [TAW-1:0]         lq_tail;

  ssm_pkg::status_t       res_st_r;
  logic [SW-1:0]          res_start_r;
  logic [LW-1:0]          res_len_r;
  logic [COLOR_BITS-1:0]  res_col_r;
  logic [CW-1:0]          res_cnt_r;

  logic [SAW-1:0]         w2_addr_r;
  logic [SW-1:0]          w2_start_r;
  logic [LW-1:0]          w2_len_r;
  logic [COLOR_BITS-1:0]  w2_col_r;

  logic                   out_valid_r;
  logic [2:0]             out_status_r;
  logic [SW-1:0]          out_start_r;
  logic [LW-1:0]          out_len_r;
  logic [ssm_pkg::OUTC_W-1:0] out_col_r;
  logic [CW-1:0]          out_cnt_r;

  logic                   accept;
  logic [PW-1:0]          pidx;
  logic                   full;
  logic [SAW-1:0]         seg_a, seg_prev, new_addr;
  logic [TAW-1:0]         t_new;

  logic [SW-1:0]          rs0, rs1;
  logic [LW-1:0]          rl0, rl1;
  logic [COLOR_BITS-1:0]  rc0, rc1;

  logic signed [14:0]     lastx, s15, cut;
  logic                   ovl, abut, same;
  logic [LW-1:0]          new_len;

  ssm_pkg::status_t       d_st;
  logic                   w1_en, w2_en, d_lwe, d_inc, d_dec;
  logic [SAW-1:0]         w1_addr, w2_addr;
  logic [SW-1:0]          w1_start, w2_start, d_rstart;
  logic [LW-1:0]          w1_len, w2_len, d_rlen;
  logic [COLOR_BITS-1:0]  w1_col, w2_col, d_rcol;
  logic [TAW-1:0]         d_tail;
  logic [CW-1:0]          d_cnt;

  logic                   sr_we;
  logic [SAW-1:0]         sr_waddr;
  logic [SW-1:0]          sr_wstart;
  logic [LW-1:0]          sr_wlen;
  logic [COLOR_BITS-1:0]  sr_wcol;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign pidx     = PW'(pool_r);
  assign full     = (pool_top_r[pidx] == TOPW'(POOL_DEPTH));
  assign t_new    = pool_top_r[pidx][TAW-1:0];
  assign seg_a    = SAW'(pool_r) * SAW'(POOL_DEPTH) + SAW'(lq_tail);
  assign seg_prev = seg_a - SAW'(1);
  assign new_addr = SAW'(pool_r) * SAW'(POOL_DEPTH) + SAW'(t_new);

  // tail relation
  assign lastx   = $signed({3'b000, rs0}) + $signed({2'b00, rl0}) - 15'sd1;
  assign s15     = $signed({3'b000, s_r});
  assign cut     = s15 - $signed({3'b000, rs0});
  assign ovl     = (lastx >= s15);
  assign abut    = (lastx == s15 - 15'sd1);
  assign same    = (rc0 == c_r);
  assign new_len = ssm_pkg::span_len(s_r, e_r);

  always_comb begin
    d_st     = ssm_pkg::ST_OVERFLOW;
    w1_en    = 1'b0;
    w1_addr  = seg_a;
    w1_start = s_r;
    w1_len   = new_len;
    w1_col   = c_r;
    w2_en    = 1'b0;
    w2_addr  = new_addr;
    w2_start = s_r;
    w2_len   = new_len;
    w2_col   = c_r;
    d_lwe    = 1'b0;
    d_inc    = 1'b0;
    d_dec    = 1'b0;
    d_tail   = lq_tail;
    d_cnt    = lq_cnt;
    d_rstart = rs0;
    d_rlen   = rl0;
    d_rcol   = rc0;
    if (lq_cnt == '0) begin
      d_rstart = '0;
      d_rlen   = '0;
      d_rcol   = '0;
      if (!full) begin
        d_st     = ssm_pkg::ST_APPEND;
        w1_en    = 1'b1;
        w1_addr  = new_addr;
        d_lwe    = 1'b1;
        d_inc    = 1'b1;
        d_tail   = t_new;
        d_cnt    = CW'(1);
        d_rstart = s_r;
        d_rlen   = new_len;
        d_rcol   = c_r;
      end
    end else if ((ovl || abut) && same) begin
      // extend the tail up to the new end
      d_st     = ssm_pkg::ST_EXTEND;
      w1_en    = 1'b1;
      w1_start = rs0;
      w1_len   = ssm_pkg::span_len(rs0, e_r);
      w1_col   = rc0;
      d_rlen   = w1_len;
    end else if (ovl && (cut > 15'sd0)) begin
      if (!full) begin
        // cut the tail, then append the span
        d_st     = ssm_pkg::ST_APPEND;
        w1_en    = 1'b1;
        w1_start = rs0;
        w1_len   = cut[LW-1:0];
        w1_col   = rc0;
        w2_en    = 1'b1;
        d_lwe    = 1'b1;
        d_inc    = 1'b1;
        d_tail   = t_new;
        d_cnt    = (lq_cnt < ssm_pkg::CNT_MAX) ? lq_cnt + CW'(1) : lq_cnt;
        d_rstart = s_r;
        d_rlen   = new_len;
        d_rcol   = c_r;
      end
    end else if (ovl && (lq_cnt > CW'(1)) && (lq_tail != '0) && (rc1 == c_r)) begin
      // tail vanished: fold the span into the entry below
      d_st     = ssm_pkg::ST_MERGE;
      w1_en    = 1'b1;
      w1_start = rs0;
      w1_len   = '0;
      w1_col   = rc0;
      w2_en    = 1'b1;
      w2_addr  = seg_prev;
      w2_start = rs1;
      w2_len   = ssm_pkg::span_len(rs1, e_r);
      w2_col   = rc1;
      d_lwe    = 1'b1;
      d_dec    = 1'b1;
      d_tail   = lq_tail - TAW'(1);
      d_cnt    = lq_cnt - CW'(1);
      d_rstart = rs1;
      d_rlen   = w2_len;
      d_rcol   = rc1;
    end else if (ovl) begin
      d_st     = ssm_pkg::ST_REWRITE;
      w1_en    = 1'b1;
      d_rstart = s_r;
      d_rlen   = new_len;
      d_rcol   = c_r;
    end else if (!full) begin
      d_st     = ssm_pkg::ST_APPEND;
      w1_en    = 1'b1;
      w1_addr  = new_addr;
      d_lwe    = 1'b1;
      d_inc    = 1'b1;
      d_tail   = t_new;
      d_cnt    = (lq_cnt < ssm_pkg::CNT_MAX) ? lq_cnt + CW'(1) : lq_cnt;
      d_rstart = s_r;
      d_rlen   = new_len;
      d_rcol   = c_r;
    end
  end

  always_comb begin
    sr_we     = (state_r == S_SEG) ? w1_en : (state_r == S_WR2);
    sr_waddr  = (state_r == S_WR2) ? w2_addr_r  : w1_addr;
    sr_wstart = (state_r == S_WR2) ? w2_start_r : w1_start;
    sr_wlen   = (state_r == S_WR2) ? w2_len_r   : w1_len;
    sr_wcol   = (state_r == S_WR2) ? w2_col_r   : w1_col;
  end

  ssm_seg_ram #(
    .DEPTH      (SEGS),
    .AW         (SAW),
    .COLOR_BITS (COLOR_BITS)
  ) u_seg_ram (
    .clk     (clk),
    .we      (sr_we),
    .waddr   (sr_waddr),
    .wstart  (sr_wstart),
    .wlen    (sr_wlen),
    .wcolor  (sr_wcol),
    .re      (state_r == S_LINE),
    .raddr0  (seg_a),
    .raddr1  (seg_prev),
    .rstart0 (rs0),
    .rlen0   (rl0),
    .rcolor0 (rc0),
    .rstart1 (rs1),
    .rlen1   (rl1),
    .rcolor1 (rc1)
  );

  // line table
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      lm_cnt[clr_r] <= '0;
    end else if (state_r == S_SEG && d_lwe) begin
      lm_cnt[line_r]  <= d_cnt;
      lm_tail[line_r] <= d_tail;
    end
    if (accept) begin
      lq_cnt  <= lm_cnt[LAW'(in_line)];
      lq_tail <= lm_tail[LAW'(in_line)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pool_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_POOLS; i++) begin
        pool_top_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        pool_r <= cfg_wdata;
      end
      // drop the sent item unless a new one is loaded below
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + LAW'(1);
          if (clr_r == LAW'(NUM_LINES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            line_r <= LAW'(in_line);
            s_r    <= in_span_start;
            e_r    <= in_span_end;
            c_r    <= COLOR_BITS'(in_span_color);
            if (13'(in_line) >= 13'(NUM_LINES)) begin
              res_st_r    <= ssm_pkg::ST_OVERFLOW;
              res_start_r <= '0;
              res_len_r   <= '0;
              res_col_r   <= '0;
              res_cnt_r   <= '0;
              state_r     <= S_OUT;
            end else begin
              state_r <= S_LINE;
            end
          end
        end
        S_LINE: begin
          if (pool_r >= 2'(NUM_POOLS)) begin
            res_st_r    <= ssm_pkg::ST_OVERFLOW;
            res_start_r <= '0;
            res_len_r   <= '0;
            res_col_r   <= '0;
            res_cnt_r   <= lq_cnt;
            state_r     <= S_OUT;
          end else begin
            state_r <= S_SEG;
          end
        end
        S_SEG: begin
          res_st_r    <= d_st;
          res_start_r <= d_rstart;
          res_len_r   <= d_rlen;
          res_col_r   <= d_rcol;
          res_cnt_r   <= d_cnt;
          if (d_inc) begin
            pool_top_r[pidx] <= pool_top_r[pidx] + TOPW'(1);
          end else if (d_dec && pool_top_r[pidx] != '0) begin
            pool_top_r[pidx] <= pool_top_r[pidx] - TOPW'(1);
          end
          w2_addr_r  <= w2_addr;
          w2_start_r <= w2_start;
          w2_len_r   <= w2_len;
          w2_col_r   <= w2_col;
          state_r    <= w2_en ? S_WR2 : S_OUT;
        end
        S_WR2: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_st_r;
            out_start_r  <= res_start_r;
            out_len_r    <= res_len_r;
            out_col_r    <= ssm_pkg::OUTC_W'(res_col_r);
            out_cnt_r    <= res_cnt_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_tail_start       = out_start_r;
  assign out_tail_length      = out_len_r;
  assign out_tail_color       = out_col_r;
  assign out_segments_on_line = out_cnt_r;

  `SSM_CHECK(a_clear_stall, clk, rst_n, (state_r == S_CLEAR) |-> in_stall, "item taken during clear")
  `SSM_CHECK(a_accept_seq, clk, rst_n, accept |=> (state_r == S_LINE || state_r == S_OUT), "bad step after accept")
  `SSM_NEVER(a_top_bound, clk, rst_n, pool_top_r[0] > TOPW'(POOL_DEPTH), "pool top beyond depth")
  `SSM_CHECK(a_empty_tail, clk, rst_n, (out_valid && out_segments_on_line == '0) |-> (out_tail_length == '0 && out_tail_color == '0), "empty line with tail")

endmodule
